// ----- rtl/core/bdws_pkg.sv -----
// ----------------------------------------------------------------------------
// bdws_pkg
// Shared types and constants for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdws_pkg;

  localparam int DEPTH   = 16;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 32;
  localparam int POS_W   = 6;
  localparam int STAT_W  = 2;
  localparam int OCC_W   = 5;

  localparam int IN_W    = 40;
  localparam int OUT_W   = 16;

  localparam logic [MODE_W-1:0] MODE_SEARCH     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  localparam logic [POS_W-1:0] NO_POSITION = '1;

  typedef logic [2:0] cell_op_t;
  localparam cell_op_t CELL_HOLD        = 3'd0;
  localparam cell_op_t CELL_SHIFT_BACK  = 3'd1;
  localparam cell_op_t CELL_SHIFT_FRONT = 3'd2;
  localparam cell_op_t CELL_LOAD_TAIL   = 3'd3;
  localparam cell_op_t CELL_COMPARE     = 3'd4;
  localparam cell_op_t CELL_SCAN        = 3'd5;

  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  key;
  } cell_ctrl_t;

endpackage

// ----- rtl/core/bdws_cell.sv -----
// ----------------------------------------------------------------------------
// bdws_cell
// One storage slot of the deque: holds a value and a match flag, shifts
// toward either neighbor and compares against the broadcast key.
// ----------------------------------------------------------------------------
module bdws_cell (
  input  logic                                clk,
  input  bdws_pkg::cell_ctrl_t                ctrl,
  input  logic                                live,
  input  logic                                tail,
  input  logic signed [bdws_pkg::VALUE_W-1:0] prev_data,
  input  logic signed [bdws_pkg::VALUE_W-1:0] next_data,
  input  logic                                next_match,
  output logic signed [bdws_pkg::VALUE_W-1:0] data,
  output logic                                match
);
  import bdws_pkg::*;

  logic signed [VALUE_W-1:0] data_r, data_nxt;
  logic                      match_r, match_nxt;

  always_comb begin
    data_nxt  = data_r;
    match_nxt = match_r;
    case (ctrl.op)
      CELL_HOLD: begin
      end
      CELL_SHIFT_BACK:  data_nxt = prev_data;
      CELL_SHIFT_FRONT: data_nxt = next_data;
      CELL_LOAD_TAIL: begin
        if (tail) data_nxt = ctrl.key;
      end
      CELL_COMPARE:     match_nxt = live && (data_r == ctrl.key);
      CELL_SCAN:        match_nxt = next_match;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    match_r <= match_nxt;
  end

  assign data  = data_r;
  assign match = match_r;

endmodule

// ----- rtl/core/bounded_deque_with_search.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Bounded deque of signed 32-bit values built as a chain of cells, with
// push/pop at both ends and a first-match search from the front.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one transaction carries a mode and a value. Output
//   channel out_*: one result transaction per input, in order.
//   For pushes and pops the result is registered and shows on out_tvalid the
//   cycle after acceptance. A search first does a parallel compare in
//   every cell, then the match flags shift one cell per cycle toward the
//   front until cell 0 holds a match or all live cells have been passed;
//   the cells scanned before the first match are at most the occupancy.
//   One item is worked on at a time; in_tready is high when no search is
//   running and the output register is empty or being drained.
//   Reset (rst_n low, synchronous) empties the deque and drops any pending
//   result. When the receiver stalls, the result is held in the output
//   register and a finished search waits with the cells frozen.
// ----------------------------------------------------------------------------
module bounded_deque_with_search (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bdws_pkg::IN_W-1:0]  in_tdata,   // mode[2:0], value[34:3], zero pad
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bdws_pkg::OUT_W-1:0] out_tdata   // position[5:0], status[7:6],
                                                 // occupancy[12:8], zero pad
);
  import bdws_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                      state_r, state_nxt;
  logic [COUNT_W-1:0]        count_r, count_nxt;
  logic [COUNT_W-1:0]        step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]          out_pos_r, out_pos_nxt;
  logic [STAT_W-1:0]         out_stat_r, out_stat_nxt;
  logic [OCC_W-1:0]          out_occ_r, out_occ_nxt;

  logic [MODE_W-1:0]         in_mode;
  logic signed [VALUE_W-1:0] in_value;
  logic                      in_fire, slot_free, full, empty;
  logic [COUNT_W:0]          pos_sum;
  cell_ctrl_t                ctrl;

  logic signed [VALUE_W-1:0] cell_data [DEPTH];
  logic                      cell_match [DEPTH];

  assign in_mode   = in_tdata[MODE_W-1:0];
  assign in_value  = in_tdata[MODE_W+VALUE_W-1:MODE_W];
  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_fire   = in_tvalid && in_tready;
  assign full      = (count_r == COUNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign pos_sum   = {1'b0, step_r} + (COUNT_W+1)'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_stat_nxt  = out_stat_r;
    out_occ_nxt   = out_occ_r;
    ctrl.op       = CELL_HOLD;
    ctrl.key      = in_value;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_pos_nxt  = NO_POSITION;
          out_stat_nxt = ST_DONE;
          case (in_mode)
            MODE_SEARCH: begin
              ctrl.op   = CELL_COMPARE;
              step_nxt  = '0;
              state_nxt = ST_SCAN;
            end
            MODE_PUSH_FRONT: begin
              if (full) begin
                out_stat_nxt = ST_FULL;
              end else begin
                ctrl.op   = CELL_SHIFT_BACK;
                count_nxt = count_r + COUNT_W'(1);
              end
            end
            MODE_PUSH_BACK: begin
              if (full) begin
                out_stat_nxt = ST_FULL;
              end else begin
                ctrl.op   = CELL_LOAD_TAIL;
                count_nxt = count_r + COUNT_W'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (empty) begin
                out_stat_nxt = ST_EMPTY;
              end else begin
                ctrl.op   = CELL_SHIFT_FRONT;
                count_nxt = count_r - COUNT_W'(1);
              end
            end
            MODE_POP_BACK: begin
              if (empty) out_stat_nxt = ST_EMPTY;
              else count_nxt = count_r - COUNT_W'(1);
            end
            default: begin
            end
          endcase
          if (in_mode != MODE_SEARCH) begin
            out_valid_nxt = 1'b1;
            out_occ_nxt   = OCC_W'(count_nxt);
          end
        end
      end
      ST_SCAN: begin
        if (step_r == count_r || cell_match[0]) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_stat_nxt  = ST_DONE;
            out_occ_nxt   = OCC_W'(count_r);
            out_pos_nxt   = (step_r == count_r) ? NO_POSITION : POS_W'(pos_sum);
            state_nxt     = ST_IDLE;
          end
        end else begin
          ctrl.op  = CELL_SCAN;
          step_nxt = step_r + COUNT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_d, next_d;
    logic                      next_m;
    if (i == 0) begin : g_first
      assign prev_d = in_value;
    end else begin : g_mid_p
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_data[i];
      assign next_m = 1'b0;
    end else begin : g_mid_n
      assign next_d = cell_data[i+1];
      assign next_m = cell_match[i+1];
    end
    bdws_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .live       (COUNT_W'(i) < count_r),
      .tail       (COUNT_W'(i) == count_r),
      .prev_data  (prev_d),
      .next_data  (next_d),
      .next_match (next_m),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_pos_r  <= out_pos_nxt;
    out_stat_r <= out_stat_nxt;
    out_occ_r  <= out_occ_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-POS_W-STAT_W-OCC_W){1'b0}}, out_occ_r, out_stat_r, out_pos_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (step_r <= count_r))
    else $error("scan ran past occupancy");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !full && (in_mode == MODE_PUSH_FRONT || in_mode == MODE_PUSH_BACK))
      |=> (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("push did not grow occupancy");

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !in_tready)
    else $error("input accepted during search");
`endif

endmodule
